// ----- sv/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, operation codes and the status bundle of the reduce engine.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int IN_WIDTH_DEF = 32;
   localparam int FIELD_W      = 32;
   localparam int RES_W        = 64;
   localparam int OP_W         = 3;

   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB    = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL    = 3'd2;
   localparam logic [OP_W-1:0] OP_EQ     = 3'd3;
   localparam logic [OP_W-1:0] OP_ISINT  = 3'd4;
   localparam logic [OP_W-1:0] OP_REDUCE = 3'd5;

   typedef struct packed {
      logic busy;
      logic done;
   } red_stat_type;

endpackage

// ----- sv/rational_arithmetic_unit.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Add, subtract, multiply, compare, integer test and reduction of fractions.
// ----------------------------------------------------------------------------
// A request carries an operation code and two fractions of signed numerator
// and denominator; each operand is taken as its low IN_WIDTH bits. Each
// request gives exactly one response with a 64-bit numerator and denominator,
// a truth bit for the tests and an error bit for a zero denominator in use.
// Requests are taken one at a time: req_ready is high only while the
// sequencer is idle. Add, subtract, multiply and equal run four products
// through one shared registered multiplier. Reduce runs a binary gcd of up
// to 2*IN_WIDTH steps and then divides both magnitudes by it in IN_WIDTH
// steps. The integer test, unused codes and zero denominators go straight
// from idle to the finish state.
// The response sits in an output register; a new request is accepted while
// it waits, and the next result is held back until the receiver takes it.
// Synchronous reset empties the response register and returns to idle.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
   parameter int IN_WIDTH = rau_pkg::IN_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rau_pkg::OP_W-1:0]          req_operation,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_a_num,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_a_den,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_b_num,
   input  logic signed [rau_pkg::FIELD_W-1:0] req_b_den,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [rau_pkg::RES_W-1:0]  rsp_res_num,
   output logic signed [rau_pkg::RES_W-1:0]  rsp_res_den,
   output logic                              rsp_truth,
   output logic                              rsp_error
);

   localparam int W  = IN_WIDTH;
   localparam int PW = 2 * IN_WIDTH;
   localparam int RW = rau_pkg::RES_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_RED  = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;
   logic [rau_pkg::OP_W-1:0]    op_ff, op_in;
   logic signed [W-1:0]         an_ff, an_in;
   logic signed [W-1:0]         ad_ff, ad_in;
   logic signed [W-1:0]         bn_ff, bn_in;
   logic signed [W-1:0]         bd_ff, bd_in;
   logic [2:0]                  cnt_ff, cnt_in;
   logic                        start_ff, start_in;
   logic signed [PW-1:0]        p1_ff, p1_in;
   logic signed [PW-1:0]        p2_ff, p2_in;
   logic signed [PW-1:0]        dd_ff, dd_in;
   logic [RW-1:0]               stg_num_ff, stg_num_in;
   logic [RW-1:0]               stg_den_ff, stg_den_in;
   logic                        stg_truth_ff, stg_truth_in;
   logic                        stg_err_ff, stg_err_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]               rsp_num_ff, rsp_num_in;
   logic [RW-1:0]               rsp_den_ff, rsp_den_in;
   logic                        rsp_truth_ff, rsp_truth_in;
   logic                        rsp_error_ff, rsp_error_in;

   logic signed [W-1:0]         a_num_w, a_den_w, b_num_w, b_den_w;
   logic                        ad_zero, bd_zero;
   logic signed [W-1:0]         mul_a, mul_b;
   logic signed [PW-1:0]        prod;
   logic [W-1:0]                mag_num, mag_den;
   logic                        neg;
   rau_pkg::red_stat_type       red_stat;
   logic [W-1:0]                q_num, q_den;
   logic [RW-1:0]               qn_ext;

   assign a_num_w = req_a_num[W-1:0];
   assign a_den_w = req_a_den[W-1:0];
   assign b_num_w = req_b_num[W-1:0];
   assign b_den_w = req_b_den[W-1:0];
   assign ad_zero = a_den_w == '0;
   assign bd_zero = b_den_w == '0;

   always_comb begin
      case (cnt_ff)
         3'd0: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
         3'd1: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         3'd2: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bn_ff;
         end
      endcase
   end

   rau_mult #(
      .IN_WIDTH(IN_WIDTH)
   ) u_mult (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign mag_num = an_ff[W-1] ? (~an_ff) + W'(1) : an_ff;
   assign mag_den = ad_ff[W-1] ? (~ad_ff) + W'(1) : ad_ff;
   assign neg     = an_ff[W-1] ^ ad_ff[W-1];

   rau_reduce #(
      .IN_WIDTH(IN_WIDTH)
   ) u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (start_ff),
      .num_mag (mag_num),
      .den_mag (mag_den),
      .stat    (red_stat),
      .q_num   (q_num),
      .q_den   (q_den)
   );

   assign qn_ext = RW'(q_num);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      an_in        = an_ff;
      ad_in        = ad_ff;
      bn_in        = bn_ff;
      bd_in        = bd_ff;
      cnt_in       = cnt_ff;
      start_in     = 1'b0;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      dd_in        = dd_ff;
      stg_num_in   = stg_num_ff;
      stg_den_in   = stg_den_ff;
      stg_truth_in = stg_truth_ff;
      stg_err_in   = stg_err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      rsp_truth_in = rsp_truth_ff;
      rsp_error_in = rsp_error_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in        = req_operation;
               an_in        = a_num_w;
               ad_in        = a_den_w;
               bn_in        = b_num_w;
               bd_in        = b_den_w;
               cnt_in       = '0;
               stg_num_in   = '0;
               stg_den_in   = '0;
               stg_truth_in = 1'b0;
               stg_err_in   = 1'b0;
               state_in     = S_FIN;
               case (req_operation)
                  rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL, rau_pkg::OP_EQ: begin
                     if (ad_zero || bd_zero) begin
                        stg_err_in = 1'b1;
                     end else begin
                        state_in = S_MUL;
                     end
                  end
                  rau_pkg::OP_ISINT: begin
                     stg_err_in   = ad_zero;
                     stg_truth_in = a_den_w == W'(1);
                  end
                  rau_pkg::OP_REDUCE: begin
                     if (ad_zero) begin
                        stg_err_in = 1'b1;
                     end else begin
                        start_in = 1'b1;
                        state_in = S_RED;
                     end
                  end
                  default: begin
                     stg_err_in = 1'b0;
                  end
               endcase
            end
         end
         S_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff)
               3'd1: p1_in = prod;
               3'd2: p2_in = prod;
               3'd3: dd_in = prod;
               3'd4: begin
                  state_in = S_FIN;
                  case (op_ff)
                     rau_pkg::OP_ADD: begin
                        stg_num_in = RW'(p1_ff) + RW'(p2_ff);
                        stg_den_in = RW'(dd_ff);
                     end
                     rau_pkg::OP_SUB: begin
                        stg_num_in = RW'(p1_ff) - RW'(p2_ff);
                        stg_den_in = RW'(dd_ff);
                     end
                     rau_pkg::OP_MUL: begin
                        stg_num_in = RW'(prod);
                        stg_den_in = RW'(dd_ff);
                     end
                     default: begin
                        stg_truth_in = p1_ff == p2_ff;
                     end
                  endcase
               end
               default: begin
                  cnt_in = cnt_ff + 1'b1;
               end
            endcase
         end
         S_RED: begin
            if (red_stat.done) begin
               stg_num_in = neg ? RW'(0) - qn_ext : qn_ext;
               stg_den_in = RW'(q_den);
               state_in   = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_num_in   = stg_num_ff;
               rsp_den_in   = stg_den_ff;
               rsp_truth_in = stg_truth_ff;
               rsp_error_in = stg_err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      an_ff        <= an_in;
      ad_ff        <= ad_in;
      bn_ff        <= bn_in;
      bd_ff        <= bd_in;
      cnt_ff       <= cnt_in;
      p1_ff        <= p1_in;
      p2_ff        <= p2_in;
      dd_ff        <= dd_in;
      stg_num_ff   <= stg_num_in;
      stg_den_ff   <= stg_den_in;
      stg_truth_ff <= stg_truth_in;
      stg_err_ff   <= stg_err_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_den_ff   <= rsp_den_in;
      rsp_truth_ff <= rsp_truth_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign req_ready   = state_ff == S_IDLE;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_res_num = rsp_num_ff;
   assign rsp_res_den = rsp_den_ff;
   assign rsp_truth   = rsp_truth_ff;
   assign rsp_error   = rsp_error_ff;

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("A request was accepted while another was in progress.");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error) |-> (rsp_res_num == '0 && rsp_res_den == '0 && !rsp_truth))
      else $error("An error response carries a nonzero result.");

   a_truth_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_truth) |-> (rsp_res_num == '0 && rsp_res_den == '0))
      else $error("A test response carries a nonzero fraction.");

   a_reduce_owned: assert property (@(posedge clock) disable iff (reset)
      red_stat.done |-> (state_ff == S_RED))
      else $error("The reduce engine finished outside a reduce request.");

   a_reduce_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RED && !start_ff && !red_stat.done) |-> red_stat.busy)
      else $error("The reduce engine went idle before delivering its result.");

endmodule

// ----- sv/rau_mult.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit shared multiplier
// One signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module rau_mult #(
   parameter int IN_WIDTH = rau_pkg::IN_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic signed [IN_WIDTH-1:0]  mul_a,
   input  logic signed [IN_WIDTH-1:0]  mul_b,
   output logic signed [2*IN_WIDTH-1:0] prod
);

   logic signed [2*IN_WIDTH-1:0] prod_ff;
   logic signed [2*IN_WIDTH-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- sv/rau_reduce.sv -----
// ----------------------------------------------------------------------------
// Rational arithmetic unit reduce engine
// Binary gcd, one subtract or shift step per cycle, followed by a two-lane
// restoring divider that divides both magnitudes by the gcd, one bit a cycle.
// ----------------------------------------------------------------------------
module rau_reduce #(
   parameter int IN_WIDTH = rau_pkg::IN_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [IN_WIDTH-1:0]   num_mag,
   input  logic [IN_WIDTH-1:0]   den_mag,
   output rau_pkg::red_stat_type stat,
   output logic [IN_WIDTH-1:0]   q_num,
   output logic [IN_WIDTH-1:0]   q_den
);

   localparam int W  = IN_WIDTH;
   localparam int KW = $clog2(W);

   typedef enum logic [2:0] {
      R_IDLE = 3'b001,
      R_GCD  = 3'b010,
      R_DIV  = 3'b100
   } rstate_type;

   rstate_type    state_ff, state_in;
   logic          done_ff, done_in;
   logic [W-1:0]  x_ff, x_in;
   logic [W-1:0]  y_ff, y_in;
   logic [KW-1:0] k_ff, k_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  g_ff, g_in;
   logic [W-1:0]  qn_ff, qn_in;
   logic [W-1:0]  qd_ff, qd_in;
   logic [W-1:0]  rn_ff, rn_in;
   logic [W-1:0]  rd_ff, rd_in;

   logic [W-1:0]  rs_n, rs_d;
   logic          ge_n, ge_d;

   assign rs_n = {rn_ff[W-2:0], qn_ff[W-1]};
   assign rs_d = {rd_ff[W-2:0], qd_ff[W-1]};
   assign ge_n = rs_n >= g_ff;
   assign ge_d = rs_d >= g_ff;

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      x_in     = x_ff;
      y_in     = y_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      g_in     = g_ff;
      qn_in    = qn_ff;
      qd_in    = qd_ff;
      rn_in    = rn_ff;
      rd_in    = rd_ff;
      case (state_ff)
         R_IDLE: begin
            if (start) begin
               x_in     = num_mag;
               y_in     = den_mag;
               qn_in    = num_mag;
               qd_in    = den_mag;
               k_in     = '0;
               state_in = R_GCD;
            end
         end
         R_GCD: begin
            if (x_ff == '0 || y_ff == '0) begin
               g_in     = (x_ff | y_ff) << k_ff;
               rn_in    = '0;
               rd_in    = '0;
               cnt_in   = KW'(W - 1);
               state_in = R_DIV;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_in = x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = (x_ff - y_ff) >> 1;
            end else begin
               y_in = (y_ff - x_ff) >> 1;
            end
         end
         R_DIV: begin
            rn_in = ge_n ? rs_n - g_ff : rs_n;
            rd_in = ge_d ? rs_d - g_ff : rs_d;
            qn_in = {qn_ff[W-2:0], ge_n};
            qd_in = {qd_ff[W-2:0], ge_d};
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = R_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      y_ff   <= y_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      g_ff   <= g_in;
      qn_ff  <= qn_in;
      qd_ff  <= qd_in;
      rn_ff  <= rn_in;
      rd_ff  <= rd_in;
   end

   assign stat.busy = state_ff != R_IDLE;
   assign stat.done = done_ff;
   assign q_num     = qn_ff;
   assign q_den     = qd_ff;

endmodule
